// ===== design/cpbm_pkg.sv =====
// Shared types and codes for the clock page buffer manager.
`timescale 1ns / 1ps
package cpbm_pkg;

    // Command codes of an input item
    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_ALLOC    = 3'd1;
    localparam logic [2:0] CMD_UNPIN    = 3'd2;
    localparam logic [2:0] CMD_DISPOSE  = 3'd3;
    localparam logic [2:0] CMD_FLUSH    = 3'd4;

    // Status codes of a result item
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_ALL_PINNED  = 3'd1;
    localparam logic [2:0] STAT_NOT_RESIDENT = 3'd2;
    localparam logic [2:0] STAT_NOT_PINNED  = 3'd3;
    localparam logic [2:0] STAT_FLUSH_PINNED = 3'd4;

    // Classified operations handed from front to back
    localparam logic [1:0] OP_PIN     = 2'd0;
    localparam logic [1:0] OP_UNPIN   = 2'd1;
    localparam logic [1:0] OP_DISPOSE = 2'd2;
    localparam logic [1:0] OP_FLUSH   = 2'd3;

    localparam int TAG_W = 40;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  file_id;
        logic [31:0] page_id;
        logic        mark_dirty;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  frame;
        logic        hit;
        logic        evicted_valid;
        logic [7:0]  evicted_file;
        logic [31:0] evicted_page;
        logic        write_back;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  file_id;
        logic [31:0] page_id;
        logic        mark_dirty;
    } t_job;

endpackage

// ===== design/cpbm_fifo.sv =====
// Small register queue used between the stages of the buffer manager.
`timescale 1ns / 1ps
module cpbm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // advance pointers with wrap
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // hold item storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== design/cpbm_front.sv =====
// Front end: accepts input items, classifies commands and queues jobs.
`timescale 1ns / 1ps
module cpbm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cpbm_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_job_pop,
    output cpbm_pkg::t_job    o_job,
    output logic              o_job_empty
);
    cpbm_pkg::t_job job;
    logic           known;

    // classify the command; drop undefined codes
    always_comb begin
        known          = 1'b1;
        job.file_id    = i_item.file_id;
        job.page_id    = i_item.page_id;
        job.mark_dirty = i_item.mark_dirty;
        job.op         = cpbm_pkg::OP_PIN;
        unique case (i_item.cmd)
            cpbm_pkg::CMD_READ, cpbm_pkg::CMD_ALLOC: job.op = cpbm_pkg::OP_PIN;
            cpbm_pkg::CMD_UNPIN:   job.op = cpbm_pkg::OP_UNPIN;
            cpbm_pkg::CMD_DISPOSE: job.op = cpbm_pkg::OP_DISPOSE;
            cpbm_pkg::CMD_FLUSH:   job.op = cpbm_pkg::OP_FLUSH;
            default:               known  = 1'b0;
        endcase
    end

    cpbm_fifo #(
        .W     ($bits(cpbm_pkg::t_job)),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && known),
        .i_data  (job),
        .o_full  (o_full),
        .i_pop   (i_job_pop),
        .o_data  (o_job),
        .o_empty (o_job_empty)
    );

endmodule

// ===== design/cpbm_engine.sv =====
// Back end: frame table, tag search, clock sweep and flush sequencer.
`timescale 1ns / 1ps
module cpbm_engine #(
    parameter int NUM_FRAMES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpbm_pkg::t_job     i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    output logic               o_res_push,
    output cpbm_pkg::t_out_item o_res,
    input  logic               i_res_full
);
    localparam int FW = $clog2(NUM_FRAMES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_FEND  = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_EVRD  = 3'd5;
    localparam logic [2:0] S_EVICT = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [FW-1:0] r_idx, n_idx, r_hand, n_hand, nh, rd_addr, wa;
    logic        r_allpin, n_allpin, allpin_c;
    cpbm_pkg::t_job r_job, n_job;

    logic        r_valid [NUM_FRAMES];
    logic        n_valid [NUM_FRAMES];
    logic [7:0]  r_pins  [NUM_FRAMES];
    logic [7:0]  n_pins  [NUM_FRAMES];
    logic        r_ref   [NUM_FRAMES];
    logic        n_ref   [NUM_FRAMES];
    logic        r_dirty [NUM_FRAMES];
    logic        n_dirty [NUM_FRAMES];

    logic [cpbm_pkg::TAG_W-1:0] r_tag [NUM_FRAMES];
    logic [cpbm_pkg::TAG_W-1:0] r_rd_tag;
    logic        we;

    logic        cv, tag_hit, fmatch, last_idx;
    logic [7:0]  cp;

    assign cv       = r_valid[r_idx];
    assign cp       = r_pins[r_idx];
    assign tag_hit  = cv && (r_rd_tag == {r_job.file_id, r_job.page_id});
    assign fmatch   = cv && (r_rd_tag[cpbm_pkg::TAG_W-1 -: 8] == r_job.file_id);
    assign last_idx = (r_idx == FW'(NUM_FRAMES - 1));
    assign allpin_c = r_allpin && cv && (cp != 8'd0);
    assign nh       = (r_hand == FW'(NUM_FRAMES - 1)) ? '0 : r_hand + 1'b1;
    assign rd_addr  = (r_state == S_EVRD || r_state == S_EVICT) ? r_hand : r_idx;

    // sequence one job through search, sweep or flush
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_hand   = r_hand;
        n_allpin = r_allpin;
        n_job    = r_job;
        n_valid  = r_valid;
        n_pins   = r_pins;
        n_ref    = r_ref;
        n_dirty  = r_dirty;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;
        we = 1'b0;
        wa = r_hand;
        unique case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_idx     = '0;
                    n_allpin  = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_job.op == cpbm_pkg::OP_FLUSH) begin
                    if (fmatch && cp != 8'd0) begin
                        if (!i_res_full) begin
                            o_res_push   = 1'b1;
                            o_res.frame  = 4'(r_idx);
                            o_res.status = cpbm_pkg::STAT_FLUSH_PINNED;
                            n_state      = S_IDLE;
                        end
                    end else if (!(fmatch && r_dirty[r_idx]) || !i_res_full) begin
                        if (fmatch) begin
                            if (r_dirty[r_idx]) begin
                                o_res_push          = 1'b1;
                                o_res.frame         = 4'(r_idx);
                                o_res.evicted_valid = 1'b1;
                                o_res.evicted_file  = r_rd_tag[cpbm_pkg::TAG_W-1 -: 8];
                                o_res.evicted_page  = r_rd_tag[31:0];
                                o_res.write_back    = 1'b1;
                                o_res.last          = 1'b0;
                            end
                            n_valid[r_idx] = 1'b0;
                            n_pins[r_idx]  = 8'd0;
                            n_ref[r_idx]   = 1'b0;
                            n_dirty[r_idx] = 1'b0;
                        end
                        if (last_idx) begin
                            n_state = S_FEND;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_RD;
                        end
                    end
                end else if (tag_hit) begin
                    if (!i_res_full) begin
                        o_res_push  = 1'b1;
                        o_res.frame = 4'(r_idx);
                        n_state     = S_IDLE;
                        case (r_job.op)
                            cpbm_pkg::OP_PIN: begin
                                o_res.hit    = 1'b1;
                                n_ref[r_idx] = 1'b1;
                                if (cp != 8'hFF) begin
                                    n_pins[r_idx] = cp + 8'd1;
                                end
                            end
                            cpbm_pkg::OP_UNPIN: begin
                                if (cp == 8'd0) begin
                                    o_res.status = cpbm_pkg::STAT_NOT_PINNED;
                                end else begin
                                    n_pins[r_idx] = cp - 8'd1;
                                    if (r_job.mark_dirty) begin
                                        n_dirty[r_idx] = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                n_valid[r_idx] = 1'b0;
                                n_pins[r_idx]  = 8'd0;
                                n_ref[r_idx]   = 1'b0;
                                n_dirty[r_idx] = 1'b0;
                            end
                        endcase
                    end
                end else if (!last_idx) begin
                    n_allpin = allpin_c;
                    n_idx    = r_idx + 1'b1;
                    n_state  = S_RD;
                end else if (r_job.op == cpbm_pkg::OP_PIN && !allpin_c) begin
                    n_state = S_SWEEP;
                end else if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    o_res.status = (r_job.op == cpbm_pkg::OP_PIN) ?
                                   cpbm_pkg::STAT_ALL_PINNED : cpbm_pkg::STAT_NOT_RESIDENT;
                    n_state      = S_IDLE;
                end
            end
            S_FEND: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (!i_res_full) begin
                    n_hand = nh;
                    if (!r_valid[nh]) begin
                        we          = 1'b1;
                        wa          = nh;
                        n_valid[nh] = 1'b1;
                        n_pins[nh]  = 8'd1;
                        n_ref[nh]   = 1'b1;
                        n_dirty[nh] = 1'b0;
                        o_res_push  = 1'b1;
                        o_res.frame = 4'(nh);
                        n_state     = S_IDLE;
                    end else if (r_pins[nh] != 8'd0) begin
                        n_state = S_SWEEP;
                    end else if (r_ref[nh]) begin
                        n_ref[nh] = 1'b0;
                    end else begin
                        n_state = S_EVRD;
                    end
                end
            end
            S_EVRD: begin
                n_state = S_EVICT;
            end
            S_EVICT: begin
                if (!i_res_full) begin
                    we                  = 1'b1;
                    o_res_push          = 1'b1;
                    o_res.frame         = 4'(r_hand);
                    o_res.evicted_valid = 1'b1;
                    o_res.evicted_file  = r_rd_tag[cpbm_pkg::TAG_W-1 -: 8];
                    o_res.evicted_page  = r_rd_tag[31:0];
                    o_res.write_back    = r_dirty[r_hand];
                    n_valid[r_hand]     = 1'b1;
                    n_pins[r_hand]      = 8'd1;
                    n_ref[r_hand]       = 1'b1;
                    n_dirty[r_hand]     = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold control state and frame flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hand   <= FW'(NUM_FRAMES - 1);
            r_idx    <= '0;
            r_allpin <= 1'b1;
            for (int k = 0; k < NUM_FRAMES; k++) begin
                r_valid[k] <= 1'b0;
                r_pins[k]  <= 8'd0;
                r_ref[k]   <= 1'b0;
                r_dirty[k] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_hand   <= n_hand;
            r_idx    <= n_idx;
            r_allpin <= n_allpin;
            r_valid  <= n_valid;
            r_pins   <= n_pins;
            r_ref    <= n_ref;
            r_dirty  <= n_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    // tag store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_tag[wa] <= {r_job.file_id, r_job.page_id};
        end
        r_rd_tag <= r_tag[rd_addr];
    end

endmodule

// ===== design/clock_page_buffer_manager.sv =====
// Top level of the clock page buffer manager.
// Usage: commands enter through a queue port (push, full, i_item); an item is
// taken when push is high and full is low. Results leave through a queue port
// (empty, pop, o_item); the oldest result is shown while empty is low and is
// taken when pop is high. Read, allocate, unpin and dispose give one result;
// flush gives one result per dirty frame of the file and a closing result,
// the last one marked by o_item.last; a pinned frame of the file instead ends
// flush with a STAT_FLUSH_PINNED result. Undefined commands give no result.
// The tag search reads the frames in order, each through S_RD and S_CHK; a
// miss adds the clock sweep, one frame per cycle while the result queue is
// not full, over up to 2*NUM_FRAMES frames. Jobs are handled one at a time.
// A two-entry command queue and a two-entry result queue decouple the ports
// from the engine; while the result queue is full the engine waits.
// Reset (synchronous, active low) frees all frames and parks the hand on the
// last frame.
`timescale 1ns / 1ps
module clock_page_buffer_manager #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  cpbm_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output cpbm_pkg::t_out_item o_item
);
    cpbm_pkg::t_job      job;
    logic                job_empty, job_pop;
    cpbm_pkg::t_out_item res;
    logic                res_push, res_full;

    cpbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_job_pop   (job_pop),
        .o_job       (job),
        .o_job_empty (job_empty)
    );

    cpbm_engine #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // queue results towards the receiver
    cpbm_fifo #(
        .W     ($bits(cpbm_pkg::t_out_item)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_item),
        .o_empty (empty)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the clock page buffer manager.
`timescale 1ns / 1ps
module tb_top;

    localparam int NF        = 16;
    localparam int DRAIN_CYC = 6 * NF + 40;
    localparam int CYC_LIMIT = 600000;
    localparam int HOLD_CYC  = 400;

    // Frame table predictor and store of expected result items
    class frame_table_sb;
        bit                  valid [NF];
        bit [7:0]            pins  [NF];
        bit                  refb  [NF];
        bit                  dirty [NF];
        bit [7:0]            file  [NF];
        bit [31:0]           page  [NF];
        int                  hand;
        cpbm_pkg::t_out_item expected_results [$];
        int                  errors;

        function void clear_all();
            for (int i = 0; i < NF; i++) begin
                valid[i] = 0;
                pins[i]  = 0;
                refb[i]  = 0;
                dirty[i] = 0;
                file[i]  = 0;
                page[i]  = 0;
            end
            hand = NF - 1;
            errors = 0;
        endfunction

        function int find_frame(bit [7:0] f, bit [31:0] p);
            for (int i = 0; i < NF; i++)
                if (valid[i] && file[i] == f && page[i] == p)
                    return i;
            return -1;
        endfunction

        function void add(int fr, bit hit, bit ev, bit [7:0] ef, bit [31:0] ep,
                          bit wb, bit [2:0] st, bit lst);
            cpbm_pkg::t_out_item r;
            r.frame = fr[3:0];
            r.hit = hit;
            r.evicted_valid = ev;
            r.evicted_file = ef;
            r.evicted_page = ep;
            r.write_back = wb;
            r.status = st;
            r.last = lst;
            expected_results.push_back(r);
        endfunction

        function void pin_or_place(bit [7:0] f, bit [31:0] p);
            int i;
            bit all_pinned;
            bit ev, wb;
            bit [7:0] ef;
            bit [31:0] ep;
            i = find_frame(f, p);
            all_pinned = 1;
            ev = 0; wb = 0; ef = 0; ep = 0;
            if (i >= 0) begin
                refb[i] = 1;
                if (pins[i] != 8'hFF)
                    pins[i]++;
                add(i, 1, 0, 0, 0, 0, cpbm_pkg::STAT_OK, 1);
                return;
            end
            for (int k = 0; k < NF; k++)
                if (!valid[k] || pins[k] == 0)
                    all_pinned = 0;
            if (all_pinned) begin
                add(0, 0, 0, 0, 0, 0, cpbm_pkg::STAT_ALL_PINNED, 1);
                return;
            end
            // sweep the clock hand until a frame is free or evictable
            forever begin
                hand = (hand + 1) % NF;
                if (!valid[hand])
                    break;
                if (pins[hand] != 0)
                    continue;
                if (refb[hand]) begin
                    refb[hand] = 0;
                    continue;
                end
                ev = 1;
                ef = file[hand];
                ep = page[hand];
                wb = dirty[hand];
                break;
            end
            valid[hand] = 1;
            pins[hand]  = 1;
            refb[hand]  = 1;
            dirty[hand] = 0;
            file[hand]  = f;
            page[hand]  = p;
            add(hand, 0, ev, ef, ep, wb, cpbm_pkg::STAT_OK, 1);
        endfunction

        function void free_frame(int i);
            valid[i] = 0;
            pins[i]  = 0;
            refb[i]  = 0;
            dirty[i] = 0;
        endfunction

        function void note_command(cpbm_pkg::t_in_item it);
            int i;
            bit done;
            case (it.cmd)
                cpbm_pkg::CMD_READ, cpbm_pkg::CMD_ALLOC: pin_or_place(it.file_id, it.page_id);
                cpbm_pkg::CMD_UNPIN: begin
                    i = find_frame(it.file_id, it.page_id);
                    if (i < 0)
                        add(0, 0, 0, 0, 0, 0, cpbm_pkg::STAT_NOT_RESIDENT, 1);
                    else if (pins[i] == 0)
                        add(i, 0, 0, 0, 0, 0, cpbm_pkg::STAT_NOT_PINNED, 1);
                    else begin
                        if (it.mark_dirty)
                            dirty[i] = 1;
                        pins[i]--;
                        add(i, 0, 0, 0, 0, 0, cpbm_pkg::STAT_OK, 1);
                    end
                end
                cpbm_pkg::CMD_DISPOSE: begin
                    i = find_frame(it.file_id, it.page_id);
                    if (i < 0)
                        add(0, 0, 0, 0, 0, 0, cpbm_pkg::STAT_NOT_RESIDENT, 1);
                    else begin
                        free_frame(i);
                        add(i, 0, 0, 0, 0, 0, cpbm_pkg::STAT_OK, 1);
                    end
                end
                cpbm_pkg::CMD_FLUSH: begin
                    done = 0;
                    for (int k = 0; k < NF && !done; k++) begin
                        if (valid[k] && file[k] == it.file_id) begin
                            if (pins[k] != 0) begin
                                add(k, 0, 0, 0, 0, 0, cpbm_pkg::STAT_FLUSH_PINNED, 1);
                                done = 1;
                            end else begin
                                if (dirty[k])
                                    add(k, 0, 1, file[k], page[k], 1, cpbm_pkg::STAT_OK, 0);
                                free_frame(k);
                            end
                        end
                    end
                    if (!done)
                        add(0, 0, 0, 0, 0, 0, cpbm_pkg::STAT_OK, 1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(cpbm_pkg::t_out_item got);
            cpbm_pkg::t_out_item want;
            if (expected_results.size() == 0) begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.frame !== want.frame) begin
                $error("frame: expected %0d, got %0d", want.frame, got.frame);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.evicted_valid !== want.evicted_valid) begin
                $error("evicted_valid: expected %0d, got %0d",
                       want.evicted_valid, got.evicted_valid);
                errors++;
            end
            if (got.evicted_file !== want.evicted_file) begin
                $error("evicted_file: expected %0h, got %0h",
                       want.evicted_file, got.evicted_file);
                errors++;
            end
            if (got.evicted_page !== want.evicted_page) begin
                $error("evicted_page: expected %0h, got %0h",
                       want.evicted_page, got.evicted_page);
                errors++;
            end
            if (got.write_back !== want.write_back) begin
                $error("write_back: expected %0d, got %0d", want.write_back, got.write_back);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                pop = 1'b0;
    logic                full;
    logic                empty;
    cpbm_pkg::t_in_item  i_item = '0;
    cpbm_pkg::t_out_item o_item;

    frame_table_sb sb = new();
    int  cyc = 0;
    bit  calm = 0;
    bit  hold_req = 0;
    bit [7:0]  file_pool [4];
    bit [31:0] page_pool [8];

    clock_page_buffer_manager #(.NUM_FRAMES(NF)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_item (i_item),
        .empty  (empty),
        .pop    (pop),
        .o_item (o_item)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Count cycles, open a calm window, and stop a hung run
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        calm <= (cyc >= 9000 && cyc < 14000);
        if (cyc > CYC_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: pop at random, hold off for a long stretch on request
    initial begin
        int held;
        held = 0;
        forever begin
            if (hold_req && held < HOLD_CYC) begin
                pop <= 1'b0;
                held++;
            end else
                pop <= calm || ($urandom_range(99) >= 6);
            @(posedge i_clk);
            if (pop && !empty && i_rst_n)
                sb.check_result(o_item);
        end
    end

    // Offer one item and wait until the block takes it
    task automatic send_item(cpbm_pkg::t_in_item it);
        if (!calm && $urandom_range(99) < 6) begin
            push <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_command(it);
    endtask

    task automatic send_cmd(bit [2:0] c, bit [7:0] f, bit [31:0] p, bit md);
        cpbm_pkg::t_in_item it;
        it.cmd = c;
        it.file_id = f;
        it.page_id = p;
        it.mark_dirty = md;
        send_item(it);
    endtask

    // Pause the sender until every expected item has come back
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic send_random();
        cpbm_pkg::t_in_item it;
        int w;
        w = $urandom_range(99);
        if (w < 30)      it.cmd = cpbm_pkg::CMD_READ;
        else if (w < 45) it.cmd = cpbm_pkg::CMD_ALLOC;
        else if (w < 78) it.cmd = cpbm_pkg::CMD_UNPIN;
        else if (w < 88) it.cmd = cpbm_pkg::CMD_DISPOSE;
        else if (w < 96) it.cmd = cpbm_pkg::CMD_FLUSH;
        else             it.cmd = 3'($urandom_range(7, 5));
        if ($urandom_range(99) < 5) begin
            it.file_id = 8'($urandom);
            it.page_id = $urandom;
        end else begin
            it.file_id = file_pool[$urandom_range(3)];
            it.page_id = page_pool[$urandom_range(7)];
        end
        it.mark_dirty = $urandom_range(1);
        send_item(it);
    endtask

    initial begin
        sb.clear_all();
        file_pool[0] = 8'h00;
        file_pool[1] = 8'hFF;
        file_pool[2] = 8'($urandom);
        file_pool[3] = 8'($urandom);
        page_pool[0] = 32'h0;
        page_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 8; k++)
            page_pool[k] = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: miss, hit, unpin cases, dispose, flush, undefined code
        send_cmd(cpbm_pkg::CMD_READ, 8'h00, 32'h0, 0);
        send_cmd(cpbm_pkg::CMD_ALLOC, 8'hFF, 32'hFFFF_FFFF, 1);
        send_cmd(cpbm_pkg::CMD_READ, 8'h00, 32'h0, 0);
        send_cmd(cpbm_pkg::CMD_UNPIN, 8'h00, 32'h0, 1);
        send_cmd(cpbm_pkg::CMD_UNPIN, 8'h00, 32'h0, 0);
        send_cmd(cpbm_pkg::CMD_UNPIN, 8'h00, 32'h0, 1);
        send_cmd(cpbm_pkg::CMD_UNPIN, 8'h09, 32'h9, 0);
        send_cmd(cpbm_pkg::CMD_DISPOSE, 8'h07, 32'h7, 0);
        send_cmd(cpbm_pkg::CMD_DISPOSE, 8'hFF, 32'hFFFF_FFFF, 0);
        send_cmd(cpbm_pkg::CMD_FLUSH, 8'h00, 32'h0, 0);
        send_cmd(3'd7, 8'hFF, 32'hFFFF_FFFF, 1);
        drain();

        // Pin every frame, then miss with no victim and flush a pinned file
        for (int k = 0; k < NF; k++)
            send_cmd(cpbm_pkg::CMD_READ, 8'h01, 32'(k), 0);
        send_cmd(cpbm_pkg::CMD_READ, 8'h01, 32'd99, 0);
        send_cmd(cpbm_pkg::CMD_FLUSH, 8'h01, 32'h0, 0);
        for (int k = 0; k < NF; k++)
            send_cmd(cpbm_pkg::CMD_UNPIN, 8'h01, 32'(k), k[0]);
        send_cmd(cpbm_pkg::CMD_READ, 8'h02, 32'd5, 0);
        send_cmd(cpbm_pkg::CMD_FLUSH, 8'h01, 32'h0, 0);
        drain();

        // Saturate one pin count, then release it
        for (int k = 0; k < 258; k++)
            send_cmd(cpbm_pkg::CMD_READ, 8'h02, 32'd5, 0);
        send_cmd(cpbm_pkg::CMD_UNPIN, 8'h02, 32'd5, 1);
        send_cmd(cpbm_pkg::CMD_DISPOSE, 8'h02, 32'd5, 0);
        drain();

        // Random traffic with a long receiver hold-off in the middle
        for (int n = 0; n < 100; n++) begin
            if (n == 20)
                hold_req = 1;
            if (n == 60)
                drain();
            send_random();
        end

        drain();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
